[hw/rtl/lkt_pkg.sv]
// Shared types and constants for the linear key table.
package lkt_pkg;

    localparam int DEPTH_DEF = 64;
    localparam int KEY_W     = 32;
    localparam int PAY_W     = 32;
    localparam int CNT_OUT_W = 7;

    typedef enum logic [1:0] {
        OP_INSERT  = 2'd0,
        OP_DELETE  = 2'd1,
        OP_SEARCH  = 2'd2,
        OP_DISPLAY = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_MISS  = 2'd2,
        STAT_EMPTY = 2'd3
    } stat_t;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_SCAN  = 2'd1,
        ST_SHIFT = 2'd2,
        ST_DISP  = 2'd3
    } state_t;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [PAY_W-1:0] payload;
    } entry_t;

endpackage

[hw/rtl/lkt_mem.sv]
// Entry memory: one write port, one read port with registered read data.
module lkt_mem
    import lkt_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
)
(
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  entry_t        wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output entry_t        rdata
);

    entry_t mem [DEPTH];
    entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/linear_key_table_with_compaction_unit.sv]
// Linear key table with compaction: sequencer, output registers, entry memory.
//
//  channel  | handshake            | words
//  ---------+----------------------+----------------------------------------------
//  command  | start / busy         | opcode, key, payload
//  result   | strobe (no stall)    | status, key_out, payload_out, count_out, last
//
//  Insert, and any operation on an empty table: result in the next cycle.
//  Search/delete walk the entries one per cycle through the single memory read
//  port; a delete then shifts one entry per cycle up to the end of the table.
//  Display gives one word per cycle, n words for n entries.
//  Reset clears the entry count; memory contents need no clearing.
//  Results cannot be stalled; a new command is taken while the last word of a result is shown.
module linear_key_table_with_compaction_unit
    import lkt_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [1:0]              opcode,
    input  logic signed [KEY_W-1:0] key,
    input  logic [PAY_W-1:0]        payload,
    output logic                    strobe,
    output logic [1:0]              status,
    output logic signed [KEY_W-1:0] key_out,
    output logic [PAY_W-1:0]        payload_out,
    output logic [CNT_OUT_W-1:0]    count_out,
    output logic                    last
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = CW + 1;

    state_t           state_reg, state_next;
    op_t              op_reg, op_next;
    logic [KEY_W-1:0] key_reg, key_next;
    logic [AW-1:0]    ptr_reg, ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             strobe_reg, strobe_next;
    stat_t            status_reg, status_next;
    logic [KEY_W-1:0] okey_reg, okey_next;
    logic [PAY_W-1:0] opay_reg, opay_next;
    logic             last_reg, last_next;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    entry_t        mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    entry_t        rdata;

    logic [PW-1:0] ptr_p1, ptr_p2, cnt_ext;
    logic          more1, more2, hit, tbl_full, tbl_empty;

    lkt_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (rdata)
    );

    assign ptr_p1    = PW'(ptr_reg) + PW'(1);
    assign ptr_p2    = PW'(ptr_reg) + PW'(2);
    assign cnt_ext   = PW'(count_reg);
    assign more1     = ptr_p1 < cnt_ext;
    assign more2     = ptr_p2 < cnt_ext;
    assign hit       = rdata.key == key_reg;
    assign tbl_full  = cnt_ext == PW'(DEPTH);
    assign tbl_empty = count_reg == '0;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    case (op_t'(opcode))
                        OP_DELETE, OP_SEARCH:
                        begin
                            if (!tbl_empty)
                            begin
                                state_next = ST_SCAN;
                            end
                        end
                        OP_DISPLAY:
                        begin
                            if (!tbl_empty)
                            begin
                                state_next = ST_DISP;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (hit)
                begin
                    state_next = (op_reg == OP_DELETE && more1) ? ST_SHIFT : ST_IDLE;
                end
                else if (!more1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SHIFT:
            begin
                if (!more2)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_DISP:
            begin
                if (!more1)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        op_next     = op_reg;
        key_next    = key_reg;
        ptr_next    = ptr_reg;
        count_next  = count_reg;
        strobe_next = 1'b0;
        status_next = status_reg;
        okey_next   = okey_reg;
        opay_next   = opay_reg;
        last_next   = last_reg;
        mem_we      = 1'b0;
        mem_waddr   = ptr_reg;
        mem_wdata   = rdata;
        mem_re      = 1'b0;
        mem_raddr   = ptr_p1[AW-1:0];
        case (state_reg)
            ST_IDLE:
            begin
                mem_raddr = '0;
                if (start)
                begin
                    op_next  = op_t'(opcode);
                    key_next = key;
                    ptr_next = '0;
                    case (op_t'(opcode))
                        OP_INSERT:
                        begin
                            strobe_next = 1'b1;
                            last_next   = 1'b1;
                            if (tbl_full)
                            begin
                                status_next = STAT_FULL;
                                okey_next   = '0;
                                opay_next   = '0;
                            end
                            else
                            begin
                                mem_we      = 1'b1;
                                mem_waddr   = count_reg[AW-1:0];
                                mem_wdata   = '{key: key, payload: payload};
                                count_next  = count_reg + CW'(1);
                                status_next = STAT_OK;
                                okey_next   = key;
                                opay_next   = payload;
                            end
                        end
                        OP_DELETE, OP_SEARCH:
                        begin
                            if (tbl_empty)
                            begin
                                strobe_next = 1'b1;
                                last_next   = 1'b1;
                                status_next = STAT_MISS;
                                okey_next   = '0;
                                opay_next   = '0;
                            end
                            else
                            begin
                                mem_re = 1'b1;
                            end
                        end
                        OP_DISPLAY:
                        begin
                            if (tbl_empty)
                            begin
                                strobe_next = 1'b1;
                                last_next   = 1'b1;
                                status_next = STAT_EMPTY;
                                okey_next   = '0;
                                opay_next   = '0;
                            end
                            else
                            begin
                                mem_re = 1'b1;
                            end
                        end
                        default:
                        begin
                            mem_re = 1'b0;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (hit)
                begin
                    okey_next   = rdata.key;
                    opay_next   = rdata.payload;
                    status_next = STAT_OK;
                    last_next   = 1'b1;
                    if (op_reg == OP_DELETE)
                    begin
                        if (more1)
                        begin
                            mem_re = 1'b1;
                        end
                        else
                        begin
                            count_next  = count_reg - CW'(1);
                            strobe_next = 1'b1;
                        end
                    end
                    else
                    begin
                        strobe_next = 1'b1;
                    end
                end
                else if (more1)
                begin
                    mem_re   = 1'b1;
                    ptr_next = ptr_p1[AW-1:0];
                end
                else
                begin
                    strobe_next = 1'b1;
                    last_next   = 1'b1;
                    status_next = STAT_MISS;
                    okey_next   = '0;
                    opay_next   = '0;
                end
            end
            ST_SHIFT:
            begin
                // entry ptr+1 moves down to ptr
                mem_we   = 1'b1;
                ptr_next = ptr_p1[AW-1:0];
                if (more2)
                begin
                    mem_re    = 1'b1;
                    mem_raddr = ptr_p2[AW-1:0];
                end
                else
                begin
                    count_next  = count_reg - CW'(1);
                    strobe_next = 1'b1;
                end
            end
            ST_DISP:
            begin
                strobe_next = 1'b1;
                status_next = STAT_OK;
                okey_next   = rdata.key;
                opay_next   = rdata.payload;
                last_next   = !more1;
                if (more1)
                begin
                    mem_re   = 1'b1;
                    ptr_next = ptr_p1[AW-1:0];
                end
            end
            default:
            begin
                strobe_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        key_reg    <= key_next;
        ptr_reg    <= ptr_next;
        status_reg <= status_next;
        okey_reg   <= okey_next;
        opay_reg   <= opay_next;
        last_reg   <= last_next;
    end

    assign busy        = state_reg != ST_IDLE;
    assign strobe      = strobe_reg;
    assign status      = status_reg;
    assign key_out     = okey_reg;
    assign payload_out = opay_reg;
    assign count_out   = CNT_OUT_W'(count_reg);
    assign last        = last_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_ext <= PW'(DEPTH))
        else $error("entry count above table depth");

    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && last |-> !busy)
        else $error("final word shown while sequencer still busy");

    a_notlast_disp: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !last |-> state_reg == ST_DISP)
        else $error("non-final word outside a listing");

    a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && opcode == OP_INSERT && !tbl_full
        |=> count_reg == $past(count_reg) + CW'(1))
        else $error("insert did not grow the table");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && status == STAT_FULL |-> tbl_full)
        else $error("full reported on a table with room");
`endif

endmodule

[tb/linear_key_table_with_compaction_unit_tb.sv]
// Self-checking testbench for the linear key table: directed table, then random traffic.
module linear_key_table_with_compaction_unit_tb
    import lkt_pkg::*;
();

    localparam int DEPTH    = DEPTH_DEF;
    localparam int WD_LIMIT = 2000;
    localparam int N_RAND   = 300;
    localparam int N_DIR    = 22;

    typedef struct packed {
        stat_t                st;
        logic [KEY_W-1:0]     k;
        logic [PAY_W-1:0]     p;
        logic [CNT_OUT_W-1:0] cnt;
        logic                 fin;
    } table_word_t;

    typedef struct packed {
        op_t              op;
        logic [KEY_W-1:0] k;
        logic [PAY_W-1:0] p;
        logic             has_exp;
        table_word_t      exp_word;
    } dir_row_t;

    logic                    clk;
    logic                    rst_n;
    logic                    start;
    logic                    busy;
    logic [1:0]              opcode;
    logic signed [KEY_W-1:0] key;
    logic [PAY_W-1:0]        payload;
    logic                    strobe;
    logic [1:0]              status;
    logic signed [KEY_W-1:0] key_out;
    logic [PAY_W-1:0]        payload_out;
    logic [CNT_OUT_W-1:0]    count_out;
    logic                    last;

    logic [KEY_W-1:0] tbl_key [DEPTH];
    logic [PAY_W-1:0] tbl_pay [DEPTH];
    int               tbl_cnt;
    table_word_t      pending_words[$];
    dir_row_t         dir_rows [N_DIR];
    int               err_cnt;
    int               quiet_cycles;

    linear_key_table_with_compaction_unit #(
        .DEPTH(DEPTH)
    ) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .opcode     (opcode),
        .key        (key),
        .payload    (payload),
        .strobe     (strobe),
        .status     (status),
        .key_out    (key_out),
        .payload_out(payload_out),
        .count_out  (count_out),
        .last       (last)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic dir_row_t mk_row(op_t op, logic [KEY_W-1:0] k, logic [PAY_W-1:0] p,
                                        int has, stat_t s, logic [KEY_W-1:0] ek,
                                        logic [PAY_W-1:0] ep, int ec);
        dir_row_t r;
        r.op       = op;
        r.k        = k;
        r.p        = p;
        r.has_exp  = (has != 0);
        r.exp_word = '{st: s, k: ek, p: ep, cnt: CNT_OUT_W'(ec), fin: 1'b1};
        return r;
    endfunction

    function automatic void post_word(stat_t s, logic [KEY_W-1:0] k, logic [PAY_W-1:0] p,
                                      logic fin);
        table_word_t w;
        w.st  = s;
        w.k   = k;
        w.p   = p;
        w.cnt = CNT_OUT_W'(tbl_cnt);
        w.fin = fin;
        pending_words.push_back(w);
    endfunction

    // Updates the table copy and queues the words this command must produce.
    task automatic table_op(op_t op, logic [KEY_W-1:0] k, logic [PAY_W-1:0] p);
        int idx;
        int j;
        logic [KEY_W-1:0] old_k;
        logic [PAY_W-1:0] old_p;
        idx = -1;
        for (j = 0; j < tbl_cnt; j++)
            if (idx < 0 && tbl_key[j] == k)
                idx = j;
        case (op)
            OP_INSERT:
            begin
                if (tbl_cnt >= DEPTH)
                    post_word(STAT_FULL, '0, '0, 1'b1);
                else
                begin
                    tbl_key[tbl_cnt] = k;
                    tbl_pay[tbl_cnt] = p;
                    tbl_cnt++;
                    post_word(STAT_OK, k, p, 1'b1);
                end
            end
            OP_DELETE:
            begin
                if (idx < 0)
                    post_word(STAT_MISS, '0, '0, 1'b1);
                else
                begin
                    old_k = tbl_key[idx];
                    old_p = tbl_pay[idx];
                    for (j = idx; j + 1 < tbl_cnt; j++)
                    begin
                        tbl_key[j] = tbl_key[j+1];
                        tbl_pay[j] = tbl_pay[j+1];
                    end
                    tbl_cnt--;
                    post_word(STAT_OK, old_k, old_p, 1'b1);
                end
            end
            OP_SEARCH:
            begin
                if (idx < 0)
                    post_word(STAT_MISS, '0, '0, 1'b1);
                else
                    post_word(STAT_OK, tbl_key[idx], tbl_pay[idx], 1'b1);
            end
            default:
            begin
                if (tbl_cnt == 0)
                    post_word(STAT_EMPTY, '0, '0, 1'b1);
                else
                    for (j = 0; j < tbl_cnt; j++)
                        post_word(STAT_OK, tbl_key[j], tbl_pay[j], j + 1 == tbl_cnt);
            end
        endcase
    endtask

    task automatic send_word(op_t op, logic [KEY_W-1:0] k, logic [PAY_W-1:0] p);
        start   <= 1'b1;
        opcode  <= op;
        key     <= k;
        payload <= p;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        table_op(op, k, p);
    endtask

    task automatic hold_off();
        int g;
        int n;
        g = $urandom_range(0, 99);
        if (g < 60)
            n = 0;
        else if (g < 92)
            n = $urandom_range(1, 3);
        else
            n = $urandom_range(10, 40);
        if (n > 0)
        begin
            start <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    function automatic logic [KEY_W-1:0] pick_key(logic hit);
        if (hit && tbl_cnt > 0)
            return tbl_key[$urandom_range(0, tbl_cnt - 1)];
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'h0000_0000;
            3:       return 32'hffff_ffff;
            4, 5, 6: return KEY_W'($urandom_range(0, 7));
            default: return $urandom;
        endcase
    endfunction

    task automatic cmp_field(string fname, logic [31:0] e, logic [31:0] a);
        if (a !== e)
        begin
            err_cnt++;
            $display("%0t: %s mismatch, expected 0x%08h got 0x%08h", $time, fname, e, a);
        end
    endtask

    always @(posedge clk)
    begin
        table_word_t e;
        if (rst_n && strobe)
        begin
            if (pending_words.size() == 0)
            begin
                err_cnt++;
                $display("%0t: unexpected word, expected none got status %0d key 0x%08h",
                         $time, status, key_out);
            end
            else
            begin
                e = pending_words.pop_front();
                cmp_field("status", 32'(e.st), 32'(status));
                cmp_field("key_out", e.k, key_out);
                cmp_field("payload_out", e.p, payload_out);
                cmp_field("count_out", 32'(e.cnt), 32'(count_out));
                cmp_field("last", 32'(e.fin), 32'(last));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || strobe)
            quiet_cycles <= 0;
        else if (quiet_cycles >= WD_LIMIT)
        begin
            $display("[linear_key_table_with_compaction_unit] ERROR");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        int    i;
        int    r;
        int    full_hits;
        logic  filling;
        op_t   op;
        rst_n        = 1'b0;
        start        = 1'b0;
        opcode       = OP_INSERT;
        key          = '0;
        payload      = '0;
        tbl_cnt      = 0;
        err_cnt      = 0;
        quiet_cycles = 0;

        dir_rows[0]  = mk_row(OP_DISPLAY, 0, 0, 1, STAT_EMPTY, 0, 0, 0);
        dir_rows[1]  = mk_row(OP_DELETE, 5, 0, 1, STAT_MISS, 0, 0, 0);
        dir_rows[2]  = mk_row(OP_SEARCH, 0, 32'hffff_ffff, 1, STAT_MISS, 0, 0, 0);
        dir_rows[3]  = mk_row(OP_INSERT, 32'h8000_0000, 0, 1, STAT_OK, 32'h8000_0000, 0, 1);
        dir_rows[4]  = mk_row(OP_INSERT, 32'h7fff_ffff, 32'hffff_ffff, 1, STAT_OK,
                              32'h7fff_ffff, 32'hffff_ffff, 2);
        dir_rows[5]  = mk_row(OP_INSERT, 0, 32'h0000_1234, 0, STAT_OK, 0, 0, 0);
        dir_rows[6]  = mk_row(OP_INSERT, 32'hffff_ffff, 32'ha5a5_a5a5, 0, STAT_OK, 0, 0, 0);
        dir_rows[7]  = mk_row(OP_INSERT, 0, 32'h0000_5678, 0, STAT_OK, 0, 0, 0);
        dir_rows[8]  = mk_row(OP_SEARCH, 0, 32'h5a5a_5a5a, 0, STAT_OK, 0, 0, 0);
        dir_rows[9]  = mk_row(OP_SEARCH, 7, 0, 1, STAT_MISS, 0, 0, 5);
        dir_rows[10] = mk_row(OP_DISPLAY, 0, 0, 0, STAT_OK, 0, 0, 0);
        dir_rows[11] = mk_row(OP_DELETE, 0, 0, 0, STAT_OK, 0, 0, 0);
        dir_rows[12] = mk_row(OP_SEARCH, 0, 0, 0, STAT_OK, 0, 0, 0);
        dir_rows[13] = mk_row(OP_DELETE, 32'h8000_0000, 0, 0, STAT_OK, 0, 0, 0);
        dir_rows[14] = mk_row(OP_DELETE, 32'hffff_ffff, 0, 0, STAT_OK, 0, 0, 0);
        dir_rows[15] = mk_row(OP_DELETE, 32'h7fff_fffe, 0, 0, STAT_OK, 0, 0, 0);
        dir_rows[16] = mk_row(OP_DELETE, 32'h7fff_ffff, 0, 0, STAT_OK, 0, 0, 0);
        dir_rows[17] = mk_row(OP_DISPLAY, 0, 0, 0, STAT_OK, 0, 0, 0);
        dir_rows[18] = mk_row(OP_DELETE, 0, 0, 0, STAT_OK, 0, 0, 0);
        dir_rows[19] = mk_row(OP_DISPLAY, 0, 0, 1, STAT_EMPTY, 0, 0, 0);
        dir_rows[20] = mk_row(OP_INSERT, 42, 32'hdead_beef, 0, STAT_OK, 0, 0, 0);
        dir_rows[21] = mk_row(OP_DELETE, 42, 0, 0, STAT_OK, 0, 0, 0);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        for (i = 0; i < N_DIR; i++)
        begin
            send_word(dir_rows[i].op, dir_rows[i].k, dir_rows[i].p);
            if (dir_rows[i].has_exp)
                pending_words[$] = dir_rows[i].exp_word;
            hold_off();
        end

        // alternate fill-to-full and drain-to-empty stretches
        filling   = 1'b1;
        full_hits = 0;
        for (i = 0; i < N_RAND; i++)
        begin
            r = $urandom_range(0, 99);
            if (filling)
                op = (r < 75) ? OP_INSERT : (r < 85) ? OP_SEARCH :
                     (r < 93) ? OP_DELETE : OP_DISPLAY;
            else
                op = (r < 10) ? OP_INSERT : (r < 25) ? OP_SEARCH :
                     (r < 92) ? OP_DELETE : OP_DISPLAY;
            if (op == OP_INSERT && tbl_cnt == DEPTH)
                full_hits++;
            send_word(op, pick_key(op != OP_INSERT && $urandom_range(0, 99) < 75), $urandom);
            if (filling && tbl_cnt == DEPTH && full_hits >= 3)
            begin
                filling   = 1'b0;
                full_hits = 0;
            end
            else if (!filling && tbl_cnt == 0)
                filling = 1'b1;
            hold_off();
        end

        start <= 1'b0;
        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (err_cnt == 0)
            $display("[linear_key_table_with_compaction_unit] OK");
        else
            $display("[linear_key_table_with_compaction_unit] ERROR");
        $finish;
    end

endmodule

[files.f]
hw/rtl/lkt_pkg.sv
hw/rtl/lkt_mem.sv
hw/rtl/linear_key_table_with_compaction_unit.sv
tb/linear_key_table_with_compaction_unit_tb.sv
